[rtl/cst_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cst_pkg: shared types and constants of the element stiffness unit
// Field widths, the material register set, the per-entry record handed from
// the numerator engine to the divider, and the state machine encodings.
// ----------------------------------------------------------------------------
package cst_pkg;

   localparam int COORD_W  = 32;           // corner coordinates, D entries
   localparam int EDGE_W   = 33;           // edge differences b_i, c_i
   localparam int MUL_W    = 34;           // shared multiplier operand width
   localparam int PROD_W   = 2 * MUL_W;    // multiplier result width
   localparam int PAIR_W   = 66;           // product of a pair of edge differences
   localparam int LO_W     = 33;           // low split of a pair product
   localparam int DET_W    = 67;           // signed twice-area
   localparam int ABS_W    = 66;           // magnitude of twice-area
   localparam int DIV_W    = ABS_W + 1;    // divisor 2*|det|
   localparam int NUM_W    = 100;          // signed numerator accumulator
   localparam int MAG_W    = NUM_W - 1;    // numerator magnitude
   localparam int OUT_W    = 64;           // stiffness entry width
   localparam int IDX_W    = 3;            // row and column index width
   localparam int ENTRIES  = 21;           // upper-triangle entries per item
   localparam int CSR_ADDR_W = 5;          // six 32-bit registers
   localparam int CSR_DATA_W = 32;

   localparam logic [IDX_W-1:0] LAST_IDX = 3'd5;

   localparam logic [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

   // register indexes on the configuration port
   localparam logic [2:0] REG_D11 = 3'd0;
   localparam logic [2:0] REG_D12 = 3'd1;
   localparam logic [2:0] REG_D13 = 3'd2;
   localparam logic [2:0] REG_D22 = 3'd3;
   localparam logic [2:0] REG_D23 = 3'd4;
   localparam logic [2:0] REG_D33 = 3'd5;

   typedef struct packed {
      logic signed [COORD_W-1:0] d11;
      logic signed [COORD_W-1:0] d12;
      logic signed [COORD_W-1:0] d13;
      logic signed [COORD_W-1:0] d22;
      logic signed [COORD_W-1:0] d23;
      logic signed [COORD_W-1:0] d33;
   } d_regs_type;

   typedef struct packed {
      logic [MAG_W-1:0] mag;
      logic             neg;
      logic [ABS_W-1:0] absdet;
      logic             degen;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic             last;
   } entry_type;

   typedef enum logic [2:0] {
      ENG_IDLE,
      ENG_DET_A,
      ENG_DET_B,
      ENG_DET_C,
      ENG_DET_D,
      ENG_MUL,
      ENG_EMIT
   } eng_state_type;

   typedef enum logic [1:0] {
      PH_PAIR,
      PH_LO,
      PH_HI,
      PH_ADD
   } phase_type;

   typedef enum logic [2:0] {
      DV_IDLE,
      DV_FETCH,
      DV_CHECK,
      DV_ITER,
      DV_DONE
   } div_state_type;

endpackage
`default_nettype wire

[rtl/cst_csr_regs.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cst_csr_regs: material matrix register file
// APB-style slave holding the six entries of the symmetric matrix D.
// ----------------------------------------------------------------------------
module cst_csr_regs import cst_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output d_regs_type            d_regs
);

   d_regs_type d_ff, d_in;
   logic [2:0] reg_sel;
   logic       wr_en;

   assign reg_sel    = csr_paddr[4:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign d_regs     = d_ff;

   always_comb begin
      d_in = d_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_D11: d_in.d11 = csr_pwdata;
            REG_D12: d_in.d12 = csr_pwdata;
            REG_D13: d_in.d13 = csr_pwdata;
            REG_D22: d_in.d22 = csr_pwdata;
            REG_D23: d_in.d23 = csr_pwdata;
            REG_D33: d_in.d33 = csr_pwdata;
            default: d_in = d_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_D11: csr_prdata = d_ff.d11;
         REG_D12: csr_prdata = d_ff.d12;
         REG_D13: csr_prdata = d_ff.d13;
         REG_D22: csr_prdata = d_ff.d22;
         REG_D23: csr_prdata = d_ff.d23;
         REG_D33: csr_prdata = d_ff.d33;
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_ff <= '0;
      end else begin
         d_ff <= d_in;
      end
   end

endmodule
`default_nettype wire

[rtl/cst_numer_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cst_numer_engine: twice-area and stiffness numerators
// Takes a triangle, forms edge differences and twice the signed area, then
// sequences one shared multiplier over the four D terms of each entry.
// ----------------------------------------------------------------------------
module cst_numer_engine import cst_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [COORD_W-1:0] corner0_x,
   input  logic signed [COORD_W-1:0] corner0_y,
   input  logic signed [COORD_W-1:0] corner1_x,
   input  logic signed [COORD_W-1:0] corner1_y,
   input  logic signed [COORD_W-1:0] corner2_x,
   input  logic signed [COORD_W-1:0] corner2_y,
   input  d_regs_type                d_regs,
   output logic                      ent_valid,
   input  logic                      ent_ready,
   output entry_type                 ent_data
);

   function automatic logic signed [COORD_W-1:0] d_pick(input d_regs_type d,
                                                        input logic [1:0] ra,
                                                        input logic [1:0] ca);
      logic [3:0] key;
      begin
         key = {ra, ca};
         case (key) inside
            4'b0000:          d_pick = d.d11;
            4'b0001, 4'b0100: d_pick = d.d12;
            4'b0010, 4'b1000: d_pick = d.d13;
            4'b0101:          d_pick = d.d22;
            4'b0110, 4'b1001: d_pick = d.d23;
            4'b1010:          d_pick = d.d33;
            default:          d_pick = '0;
         endcase
      end
   endfunction

   eng_state_type state_ff, state_in;
   phase_type     phase_ff, phase_in;
   logic [1:0]       term_ff, term_in;
   logic [IDX_W-1:0] row_ff, row_in, col_ff, col_in;

   logic signed [EDGE_W-1:0] b0_ff, b1_ff, b2_ff, c0_ff, c1_ff, c2_ff;
   logic signed [EDGE_W-1:0] b0_in, b1_in, b2_in, c0_in, c1_in, c2_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [PAIR_W-1:0] p_ff, p_in;
   logic signed [DET_W-1:0]  det_ff, det_in;
   logic [ABS_W-1:0]         absdet_ff, absdet_in;
   logic                     degen_ff, degen_in;
   logic signed [NUM_W-1:0]  acc_ff, acc_in;

   logic signed [MUL_W-1:0]   mul_a, mul_b;
   logic signed [EDGE_W-1:0]  row_b, row_c, col_b, col_c, row_v, col_v;
   logic [1:0]                row_a, col_a;
   logic signed [COORD_W-1:0] d_sel;
   logic                      last_ent;
   logic signed [NUM_W-1:0]   acc_abs;

   // select node edges and the two nonzero strain rows for row and column
   always_comb begin
      case (row_ff[2:1])
         2'd1:    begin row_b = b1_ff; row_c = c1_ff; end
         2'd2:    begin row_b = b2_ff; row_c = c2_ff; end
         default: begin row_b = b0_ff; row_c = c0_ff; end
      endcase
      case (col_ff[2:1])
         2'd1:    begin col_b = b1_ff; col_c = c1_ff; end
         2'd2:    begin col_b = b2_ff; col_c = c2_ff; end
         default: begin col_b = b0_ff; col_c = c0_ff; end
      endcase
      if (!row_ff[0]) begin
         row_a = term_ff[1] ? 2'd2 : 2'd0;
         row_v = term_ff[1] ? row_c : row_b;
      end else begin
         row_a = term_ff[1] ? 2'd2 : 2'd1;
         row_v = term_ff[1] ? row_b : row_c;
      end
      if (!col_ff[0]) begin
         col_a = term_ff[0] ? 2'd2 : 2'd0;
         col_v = term_ff[0] ? col_c : col_b;
      end else begin
         col_a = term_ff[0] ? 2'd2 : 2'd1;
         col_v = term_ff[0] ? col_b : col_c;
      end
      d_sel = d_pick(d_regs, row_a, col_a);
   end

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ENG_DET_A: begin mul_a = MUL_W'(c2_ff); mul_b = MUL_W'(b1_ff); end
         ENG_DET_B: begin mul_a = MUL_W'(c1_ff); mul_b = MUL_W'(b2_ff); end
         ENG_MUL: begin
            case (phase_ff)
               PH_PAIR: begin
                  mul_a = MUL_W'(row_v);
                  mul_b = MUL_W'(col_v);
               end
               PH_LO: begin
                  mul_a = $signed({1'b0, prod_ff[LO_W-1:0]});
                  mul_b = MUL_W'(d_sel);
               end
               PH_HI: begin
                  mul_a = $signed({p_ff[PAIR_W-1], p_ff[PAIR_W-1:LO_W]});
                  mul_b = MUL_W'(d_sel);
               end
               default: begin mul_a = '0; mul_b = '0; end
            endcase
         end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
      prod_in = mul_a * mul_b;
   end

   assign last_ent = (row_ff == LAST_IDX) && (col_ff == LAST_IDX);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ENG_IDLE:  if (req_valid) state_in = ENG_DET_A;
         ENG_DET_A: state_in = ENG_DET_B;
         ENG_DET_B: state_in = ENG_DET_C;
         ENG_DET_C: state_in = ENG_DET_D;
         ENG_DET_D: state_in = ENG_MUL;
         ENG_MUL:   if (phase_ff == PH_ADD && term_ff == 2'd3) state_in = ENG_EMIT;
         ENG_EMIT: begin
            if (ent_ready) state_in = last_ent ? ENG_IDLE : ENG_MUL;
         end
         default:   state_in = ENG_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      b0_in = b0_ff; b1_in = b1_ff; b2_in = b2_ff;
      c0_in = c0_ff; c1_in = c1_ff; c2_in = c2_ff;
      p_in = p_ff; det_in = det_ff; absdet_in = absdet_ff; degen_in = degen_ff;
      acc_in = acc_ff; phase_in = phase_ff; term_in = term_ff;
      row_in = row_ff; col_in = col_ff;
      unique case (state_ff)
         ENG_IDLE: begin
            if (req_valid) begin
               b0_in = EDGE_W'(corner1_y) - EDGE_W'(corner2_y);
               b1_in = EDGE_W'(corner2_y) - EDGE_W'(corner0_y);
               b2_in = EDGE_W'(corner0_y) - EDGE_W'(corner1_y);
               c0_in = EDGE_W'(corner2_x) - EDGE_W'(corner1_x);
               c1_in = EDGE_W'(corner0_x) - EDGE_W'(corner2_x);
               c2_in = EDGE_W'(corner1_x) - EDGE_W'(corner0_x);
            end
         end
         ENG_DET_B: p_in = prod_ff[PAIR_W-1:0];
         ENG_DET_C: det_in = DET_W'(p_ff) - DET_W'(prod_ff);
         ENG_DET_D: begin
            absdet_in = ABS_W'(det_ff[DET_W-1] ? -det_ff : det_ff);
            degen_in  = (det_ff == '0);
            acc_in    = '0;
            row_in    = '0;
            col_in    = '0;
            term_in   = '0;
            phase_in  = PH_PAIR;
         end
         ENG_MUL: begin
            case (phase_ff)
               PH_PAIR: phase_in = PH_LO;
               PH_LO: begin
                  p_in     = prod_ff[PAIR_W-1:0];
                  phase_in = PH_HI;
               end
               PH_HI: begin
                  acc_in   = acc_ff + NUM_W'(prod_ff);
                  phase_in = PH_ADD;
               end
               default: begin
                  acc_in   = acc_ff + (NUM_W'(prod_ff) <<< LO_W);
                  phase_in = PH_PAIR;
                  term_in  = term_ff + 2'd1;
               end
            endcase
         end
         ENG_EMIT: begin
            if (ent_ready && !last_ent) begin
               acc_in   = '0;
               term_in  = '0;
               phase_in = PH_PAIR;
               if (col_ff == LAST_IDX) begin
                  row_in = row_ff + 3'd1;
                  col_in = row_ff + 3'd1;
               end else begin
                  col_in = col_ff + 3'd1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // outputs
   assign acc_abs   = acc_ff[NUM_W-1] ? -acc_ff : acc_ff;
   assign req_ready = (state_ff == ENG_IDLE);
   assign ent_valid = (state_ff == ENG_EMIT);
   always_comb begin
      ent_data.mag    = MAG_W'(acc_abs);
      ent_data.neg    = acc_ff[NUM_W-1];
      ent_data.absdet = absdet_ff;
      ent_data.degen  = degen_ff;
      ent_data.row    = row_ff;
      ent_data.col    = col_ff;
      ent_data.last   = last_ent;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ENG_IDLE;
         phase_ff <= PH_PAIR;
         term_ff  <= '0;
         row_ff   <= '0;
         col_ff   <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         term_ff  <= term_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      b0_ff <= b0_in; b1_ff <= b1_in; b2_ff <= b2_in;
      c0_ff <= c0_in; c1_ff <= c1_in; c2_ff <= c2_in;
      prod_ff   <= prod_in;
      p_ff      <= p_in;
      det_ff    <= det_in;
      absdet_ff <= absdet_in;
      degen_ff  <= degen_in;
      acc_ff    <= acc_in;
   end

endmodule
`default_nettype wire

[rtl/cst_div_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cst_div_unit: entry buffer, divider and result register
// Buffers numerator records in a memory, divides each by 2*|det| one
// quotient bit per cycle with rounding, saturates and registers the result.
// ----------------------------------------------------------------------------
module cst_div_unit import cst_pkg::*; #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    ent_valid,
   output logic                    ent_ready,
   input  entry_type               ent_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [IDX_W-1:0]        rsp_row_index,
   output logic [IDX_W-1:0]        rsp_col_index,
   output logic signed [OUT_W-1:0] rsp_entry_value,
   output logic                    rsp_degenerate,
   output logic                    rsp_last_entry
);

   localparam int DEPTH  = 2 * ENTRIES;
   localparam int PTR_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SH_W   = MAG_W + FRACTION_BITS;
   localparam int HI_W   = SH_W - OUT_W;
   localparam int ITER_W = $clog2(OUT_W);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   div_state_type state_ff, state_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [SH_W-1:0]  nn_ff, nn_in;
   logic [DIV_W-1:0] div2_ff, div2_in, rem_ff, rem_in;
   logic [OUT_W-1:0] shf_ff, shf_in, q_ff, q_in;
   logic             big_ff, big_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0] row_ff, col_ff;
   logic [OUT_W-1:0] value_ff, value_in;
   logic             degen_ff, last_ff;

   logic             wr_en, rd_en, load_out;
   logic [DIV_W:0]   trial;
   logic [HI_W-1:0]  hi_part;

   assign ent_ready = (count_ff != CNT_W'(DEPTH));
   assign wr_en     = ent_valid && ent_ready;
   assign rd_en     = (state_ff == DV_IDLE) && (count_ff != '0);
   assign load_out  = (state_ff == DV_DONE) && (!rsp_valid_ff || rsp_ready);
   assign hi_part   = nn_ff[SH_W-1:OUT_W];
   assign trial     = {rem_ff, shf_ff[OUT_W-1]};

   // buffer memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_ptr_ff] <= ent_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_ptr_ff];
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(wr_en) - CNT_W'(rd_en);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         DV_IDLE:  if (rd_en) state_in = DV_FETCH;
         DV_FETCH: state_in = DV_CHECK;
         DV_CHECK: begin
            if (rd_data_ff.degen || (DIV_W'(hi_part) >= div2_ff)) state_in = DV_DONE;
            else state_in = DV_ITER;
         end
         DV_ITER:  if (iter_ff == ITER_W'(OUT_W - 1)) state_in = DV_DONE;
         DV_DONE:  if (load_out) state_in = DV_IDLE;
         default:  state_in = DV_IDLE;
      endcase
   end

   // divider datapath
   always_comb begin
      nn_in = nn_ff; div2_in = div2_ff; rem_in = rem_ff; shf_in = shf_ff;
      q_in = q_ff; big_in = big_ff; iter_in = iter_ff;
      unique case (state_ff)
         DV_FETCH: begin
            // add |det| before the divide to round half away from zero
            nn_in   = (SH_W'(rd_data_ff.mag) << FRACTION_BITS) + SH_W'(rd_data_ff.absdet);
            div2_in = {rd_data_ff.absdet, 1'b0};
         end
         DV_CHECK: begin
            big_in  = (DIV_W'(hi_part) >= div2_ff);
            rem_in  = DIV_W'(hi_part);
            shf_in  = nn_ff[OUT_W-1:0];
            q_in    = '0;
            iter_in = '0;
         end
         DV_ITER: begin
            if (trial >= {1'b0, div2_ff}) begin
               rem_in = DIV_W'(trial - {1'b0, div2_ff});
               q_in   = {q_ff[OUT_W-2:0], 1'b1};
            end else begin
               rem_in = DIV_W'(trial);
               q_in   = {q_ff[OUT_W-2:0], 1'b0};
            end
            shf_in  = shf_ff << 1;
            iter_in = iter_ff + ITER_W'(1);
         end
         default: begin
         end
      endcase
   end

   // saturate and apply sign
   always_comb begin
      if (rd_data_ff.degen) begin
         value_in = '0;
      end else if (rd_data_ff.neg) begin
         value_in = (big_ff || (q_ff > SAT_MIN)) ? SAT_MIN : -q_ff;
      end else begin
         value_in = (big_ff || q_ff[OUT_W-1]) ? SAT_MAX : q_ff;
      end
      if (load_out) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_row_index   = row_ff;
   assign rsp_col_index   = col_ff;
   assign rsp_entry_value = value_ff;
   assign rsp_degenerate  = degen_ff;
   assign rsp_last_entry  = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= DV_IDLE;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      nn_ff   <= nn_in;
      div2_ff <= div2_in;
      rem_ff  <= rem_in;
      shf_ff  <= shf_in;
      q_ff    <= q_in;
      big_ff  <= big_in;
      iter_ff <= iter_in;
      if (load_out) begin
         row_ff   <= rd_data_ff.row;
         col_ff   <= rd_data_ff.col;
         value_ff <= value_in;
         degen_ff <= rd_data_ff.degen;
         last_ff  <= rd_data_ff.last;
      end
   end

endmodule
`default_nettype wire

[rtl/cst_element_stiffness_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cst_element_stiffness_unit: constant-strain triangle stiffness matrix
// Usage:
//  - Program D (d_11..d_33, Q16.16) through the csr_ port while idle.
//  - Send one triangle per request on req_ (valid/ready). Each request
//    produces 21 rsp_ beats: the upper triangle of K row by row, Q32.32,
//    saturated, with rsp_last_entry on the final beat and rsp_degenerate
//    set (value zero) for a zero-area triangle.
//  - Each triangle passes through the area states, then each entry through
//    the numerator sequence on one shared 34x34 multiplier and then the
//    divider; a zero-area triangle skips the divide iterations.
//  - The one-bit-per-cycle divider sets the pace of proper triangles;
//    degenerate triangles skip the divide and are paced by the numerator
//    engine.
//  - The next request is taken once the numerator engine has finished the
//    current one, while the divider still drains it from a 42-entry buffer
//    memory (two triangles deep).
//  - A stalled receiver holds the result register; the divider waits and
//    the buffer fills, then the engine and req_ready hold.
//  - Reset clears D and empties the pipeline; no clearing pass is needed.
// ----------------------------------------------------------------------------
module cst_element_stiffness_unit import cst_pkg::*; #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [COORD_W-1:0] req_corner0_x,
   input  logic signed [COORD_W-1:0] req_corner0_y,
   input  logic signed [COORD_W-1:0] req_corner1_x,
   input  logic signed [COORD_W-1:0] req_corner1_y,
   input  logic signed [COORD_W-1:0] req_corner2_x,
   input  logic signed [COORD_W-1:0] req_corner2_y,
   // result channel
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [IDX_W-1:0]          rsp_row_index,
   output logic [IDX_W-1:0]          rsp_col_index,
   output logic signed [OUT_W-1:0]   rsp_entry_value,
   output logic                      rsp_degenerate,
   output logic                      rsp_last_entry,
   // configuration port
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [CSR_DATA_W-1:0]     csr_pwdata,
   output logic [CSR_DATA_W-1:0]     csr_prdata,
   output logic                      csr_pready
);

   d_regs_type d_regs;
   logic       ent_valid;
   logic       ent_ready;
   entry_type  ent_data;

   // material registers
   cst_csr_regs u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .d_regs      (d_regs)
   );

   // twice-area and numerators, one record per stiffness entry
   cst_numer_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .corner0_x (req_corner0_x),
      .corner0_y (req_corner0_y),
      .corner1_x (req_corner1_x),
      .corner1_y (req_corner1_y),
      .corner2_x (req_corner2_x),
      .corner2_y (req_corner2_y),
      .d_regs    (d_regs),
      .ent_valid (ent_valid),
      .ent_ready (ent_ready),
      .ent_data  (ent_data)
   );

   // buffer, rounding divide, saturate, result register
   cst_div_unit #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_div (
      .clock           (clock),
      .reset           (reset),
      .ent_valid       (ent_valid),
      .ent_ready       (ent_ready),
      .ent_data        (ent_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_row_index   (rsp_row_index),
      .rsp_col_index   (rsp_col_index),
      .rsp_entry_value (rsp_entry_value),
      .rsp_degenerate  (rsp_degenerate),
      .rsp_last_entry  (rsp_last_entry)
   );

endmodule
`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Element stiffness unit testbench
// Programs the material matrix over the csr_ port, sends triangles on the
// req_ channel and checks every rsp_ entry of the 6x6 upper triangle against
// a wide-integer model of K = Be^T D Be / (2|det|), with rounding, saturation
// and the zero-area flag.
// ----------------------------------------------------------------------------
module testbench import cst_pkg::*; ();

   localparam int FRAC        = 16;
   localparam int CYCLE_LIMIT = 4000000;   // generous upper bound for the whole run
   localparam int DRAIN_WAIT  = 500;       // idle cycles after the last entry

   typedef struct {
      logic [IDX_W-1:0]        row;
      logic [IDX_W-1:0]        col;
      logic signed [OUT_W-1:0] value;
      logic                    degen;
      logic                    last;
   } stiff_entry_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic signed [COORD_W-1:0] req_corner0_x = '0;
   logic signed [COORD_W-1:0] req_corner0_y = '0;
   logic signed [COORD_W-1:0] req_corner1_x = '0;
   logic signed [COORD_W-1:0] req_corner1_y = '0;
   logic signed [COORD_W-1:0] req_corner2_x = '0;
   logic signed [COORD_W-1:0] req_corner2_y = '0;

   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [IDX_W-1:0]          rsp_row_index;
   logic [IDX_W-1:0]          rsp_col_index;
   logic signed [OUT_W-1:0]   rsp_entry_value;
   logic                      rsp_degenerate;
   logic                      rsp_last_entry;

   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]     csr_paddr = '0;
   logic [CSR_DATA_W-1:0]     csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]     csr_prdata;
   logic                      csr_pready;

   // shadow copy of the material matrix, indexed like the registers
   logic signed [COORD_W-1:0] material[6];
   stiff_entry_type           pending_entries[$];
   int                        error_count = 0;
   int                        triangles_sent = 0;
   int                        entries_checked = 0;
   int                        degenerate_seen = 0;
   int                        saturated_seen = 0;
   longint                    cycle_count = 0;
   bit                        calm = 1'b0;   // no idling on either side while set

   cst_element_stiffness_unit #(.FRACTION_BITS(FRAC)) u_dut (.*);

   always #5 clock = ~clock;

   // Run-time guard: end the run if the pipeline never drains.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d entries outstanding",
                  cycle_count, pending_entries.size());
         $display("tb: failure");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      error_count++;
      $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   // Build the 21 expected entries of one triangle from the current D.
   function automatic void predict_stiffness(
      input logic signed [COORD_W-1:0] x0, y0, x1, y1, x2, y2);
      logic signed [127:0] px[3], py[3], be[3][6], dm[3][3];
      logic signed [127:0] det, absdet, n;
      logic [127:0]        mag, num, q;
      logic                degen, neg;
      stiff_entry_type     e;
      int                  k;
      px[0] = x0; py[0] = y0;
      px[1] = x1; py[1] = y1;
      px[2] = x2; py[2] = y2;
      dm[0][0] = material[REG_D11];
      dm[0][1] = material[REG_D12]; dm[1][0] = material[REG_D12];
      dm[0][2] = material[REG_D13]; dm[2][0] = material[REG_D13];
      dm[1][1] = material[REG_D22];
      dm[1][2] = material[REG_D23]; dm[2][1] = material[REG_D23];
      dm[2][2] = material[REG_D33];
      for (int i = 0; i < 3; i++) begin
         be[0][2*i]   = py[(i+1)%3] - py[(i+2)%3];
         be[0][2*i+1] = 0;
         be[1][2*i]   = 0;
         be[1][2*i+1] = px[(i+2)%3] - px[(i+1)%3];
         be[2][2*i]   = be[1][2*i+1];
         be[2][2*i+1] = be[0][2*i];
      end
      det    = (px[1] - px[0]) * (py[2] - py[0]) - (px[2] - px[0]) * (py[1] - py[0]);
      degen  = (det == 0);
      absdet = (det < 0) ? -det : det;
      k = 0;
      for (int r = 0; r < 6; r++) begin
         for (int c = r; c < 6; c++) begin
            e.row   = r[IDX_W-1:0];
            e.col   = c[IDX_W-1:0];
            e.degen = degen;
            e.last  = (k == ENTRIES - 1);
            e.value = '0;
            if (!degen) begin
               n = 0;
               for (int a = 0; a < 3; a++)
                  for (int b = 0; b < 3; b++)
                     n += be[a][r] * dm[a][b] * be[b][c];
               neg = (n < 0);
               mag = neg ? -n : n;
               // round half away from zero: add |det| before dividing by 2|det|
               num = (mag << FRAC) + absdet;
               q   = num / (absdet << 1);
               if (neg)
                  e.value = (q > 128'h8000_0000_0000_0000) ? SAT_MIN : -q[63:0];
               else
                  e.value = (q > 128'h7FFF_FFFF_FFFF_FFFF) ? SAT_MAX : q[63:0];
            end
            pending_entries.push_back(e);
            k++;
         end
      end
   endfunction

   // Result side: random backpressure, compare each accepted entry.
   always @(posedge clock) begin
      stiff_entry_type want;
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= calm ? 1'b1 : ($urandom_range(99) >= 24);
      if (!reset && rsp_valid && rsp_ready) begin
         entries_checked++;
         if (pending_entries.size() == 0) begin
            report_mismatch($sformatf("unexpected entry row %0d col %0d",
                                      rsp_row_index, rsp_col_index));
         end else begin
            want = pending_entries.pop_front();
            if (rsp_row_index !== want.row || rsp_col_index !== want.col)
               report_mismatch($sformatf("index got (%0d,%0d) want (%0d,%0d)",
                  rsp_row_index, rsp_col_index, want.row, want.col));
            if (rsp_entry_value !== want.value)
               report_mismatch($sformatf("K(%0d,%0d) got %h want %h", want.row,
                  want.col, rsp_entry_value, want.value));
            if (rsp_degenerate !== want.degen)
               report_mismatch($sformatf("degenerate got %b want %b",
                                         rsp_degenerate, want.degen));
            if (rsp_last_entry !== want.last)
               report_mismatch($sformatf("last_entry got %b want %b at (%0d,%0d)",
                  rsp_last_entry, want.last, want.row, want.col));
            if (want.degen && want.last)
               degenerate_seen++;
            if (want.value == SAT_MAX || want.value == SAT_MIN)
               saturated_seen++;
         end
      end
   end

   // Send one triangle: optional idle gap, then hold valid until accepted.
   task automatic send_triangle(input logic signed [COORD_W-1:0] x0, y0, x1, y1, x2, y2);
      int gap;
      gap = (!calm && $urandom_range(99) < 24) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_corner0_x <= x0;
      req_corner0_y <= y0;
      req_corner1_x <= x1;
      req_corner1_y <= y1;
      req_corner2_x <= x2;
      req_corner2_y <= y2;
      do @(posedge clock); while (!req_ready);
      predict_stiffness(x0, y0, x1, y1, x2, y2);
      triangles_sent++;
   endtask

   // Drop valid and wait for every expected entry, then let the engine settle.
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_entries.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // Write one register with a setup and an access phase, then read it back.
   task automatic write_material(input logic [2:0] index, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(index) << 2;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      material[index] = value;
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== value)
         report_mismatch($sformatf("register %0d read %h want %h",
                                   index, csr_prdata, value));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_material(input logic [31:0] d11, d12, d13, d22, d23, d33);
      write_material(REG_D11, d11);
      write_material(REG_D12, d12);
      write_material(REG_D13, d13);
      write_material(REG_D22, d22);
      write_material(REG_D23, d23);
      write_material(REG_D33, d33);
   endtask

   function automatic logic signed [31:0] small_coord();
      // up to six units either side of zero, random fraction
      return $signed($urandom_range(0, 32'h000C_0000)) - 32'sh0006_0000;
   endfunction

   function automatic logic signed [31:0] any_coord();
      case ($urandom_range(3))
         0:       return $urandom;
         1:       return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
         default: return small_coord();
      endcase
   endfunction

   // D at reset is zero: every entry must be zero, flag only for zero area.
   task automatic test_reset_material();
      for (int i = 0; i < 6; i++) material[i] = '0;
      send_triangle(0, 0, 32'sh0001_0000, 0, 0, 32'sh0001_0000);
      send_triangle(32'sh0002_0000, 32'sh0002_0000, 32'sh0002_0000, 32'sh0002_0000,
                    32'sh0005_0000, 32'sh0001_0000);
      drain_pipeline();
   endtask

   // Plane-stress-like material, directed shapes and corner cases.
   task automatic test_directed_shapes();
      load_material(32'h0001_2000, 32'h0000_4000, 32'h0000_0800,
                    32'h0001_1000, 32'hFFFF_F000, 32'h0000_6000);
      send_triangle(0, 0, 32'sh0001_0000, 0, 0, 32'sh0001_0000);        // unit, ccw
      send_triangle(0, 0, 0, 32'sh0001_0000, 32'sh0001_0000, 0);        // unit, cw
      send_triangle(0, 0, 1, 0, 0, 1);                                  // tiniest area
      send_triangle(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                    32'sh8000_0000, 32'sh7FFF_FFFF);                     // full range
      send_triangle(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                    32'sh7FFF_FFFF, 32'sh8000_0000);
      send_triangle(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
                    0, 1);                                               // sliver
      send_triangle(0, 0, 0, 0, 0, 0);                                   // all same point
      send_triangle(1, 2, 1, 2, 32'sh0003_0000, 7);                     // two corners equal
      send_triangle(0, 0, 32'sh0001_0000, 32'sh0001_0000,
                    32'sh0002_0000, 32'sh0002_0000);                     // collinear
      send_triangle(32'sh8000_0000, 0, 0, 0, 32'sh7FFF_FFFF, 0);        // collinear, wide
      send_triangle(32'shFFFF_FFFF, 32'shFFFF_FFFF, 0, 0, 32'shFFFF_FFFF, 0);
      drain_pipeline();
   endtask

   // Extreme D with tiny and huge triangles drives saturation both ways.
   task automatic test_saturation();
      load_material(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send_triangle(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                    32'sh8000_0000, 32'sh8000_0001);                     // long thin
      send_triangle(0, 0, 32'sh7FFF_FFFF, 0, 0, 1);
      send_triangle(0, 0, 32'sh0001_0000, 0, 0, 32'sh0001_0000);
      drain_pipeline();
      load_material(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_triangle(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                    32'sh7FFF_FFFF, 32'sh7FFF_FFFE);
      send_triangle(0, 0, 1, 0, 0, 32'sh7FFF_FFFF);
      send_triangle(5, 5, 5, 5, 9, 9);                                   // zero area
      drain_pipeline();
   endtask

   // Random triangles under a given material: mostly proper, some degenerate.
   task automatic test_random_triangles(input int count);
      logic signed [COORD_W-1:0] c[6];
      for (int i = 0; i < count; i++) begin
         calm = (i >= count / 3) && (i < count / 2);
         foreach (c[j]) c[j] = any_coord();
         case ($urandom_range(9))
            0: begin                                  // repeated corner
               c[4] = c[0];
               c[5] = c[1];
            end
            1: begin                                  // collinear on a scaled edge
               c[4] = c[0] + 2 * (c[2] - c[0]);
               c[5] = c[1] + 2 * (c[3] - c[1]);
            end
            default: ;
         endcase
         send_triangle(c[0], c[1], c[2], c[3], c[4], c[5]);
      end
      calm = 1'b0;
      drain_pipeline();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_material();
      test_directed_shapes();
      test_saturation();
      test_random_triangles(60);
      // isotropic steel-like D in Q16.16
      load_material(32'h0001_6000, 32'h0000_6000, 32'h0000_0000,
                    32'h0001_6000, 32'h0000_0000, 32'h0000_8000);
      test_random_triangles(120);
      load_material($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      test_random_triangles(120);

      $display("covered %0d triangles, %0d entries checked (%0d zero-area triangles,",
               triangles_sent, entries_checked, degenerate_seen);
      $display("  %0d saturated entries) across six material settings", saturated_seen);
      if (error_count == 0 && pending_entries.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

[files.f]
rtl/cst_pkg.sv
rtl/cst_csr_regs.sv
rtl/cst_numer_engine.sv
rtl/cst_div_unit.sv
rtl/cst_element_stiffness_unit.sv
tb/sv/testbench.sv
